/* hw/rtl/tlbpt_pkg.sv */
// Shared types and constants for the TLB / page-table translator.
`default_nettype none

package tlbpt_pkg;

    localparam int ADDR_W  = 16;
    localparam int COUNT_W = 32;

    typedef struct packed {
        logic [ADDR_W-1:0] logical_address;
    } tlbpt_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  physical_address;
        logic               tlb_hit;
        logic               page_fault;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] fault_total;
        logic [COUNT_W-1:0] translation_total;
    } tlbpt_rsp_t;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } tlbpt_state_t;

endpackage

`default_nettype wire

/* hw/rtl/tlbpt_chan_if.sv */
// Valid/ready channel carrying one item payload.
`default_nettype none

interface tlbpt_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tlb_page_table_translator.sv */
// Top level: TLB lookup with page-table fallback and frame allocation.
//
// Usage notes
//  req : sink channel, one logical address per item (page above OFFSET_BITS,
//        offset below). Page number is reduced modulo PAGE_COUNT.
//  rsp : source channel, exactly one result item per request item: physical
//        address, hit/fault flags and three saturating running totals.
//  Order: the result is registered at the lookup edge, which ends the S_LOOK
//        state entered at the accept edge (S_LOOK waits while rsp is stalled), so
//        rsp.valid is high from that edge. No new item is taken before the lookup,
//        as the registered page-table RAM read sits between accept and resolve/write-back.
//  TLB: TLB_ENTRIES tags compared in parallel in flops; fills go
//        round-robin (FIFO). Page table: one RAM word per page holding
//        {valid, frame}; a fault writes it back in the resolve cycle.
//  Reset: control state clears at once, then a clearing pass writes every
//        page-table word to zero, one per cycle, with req.ready low for its length.
//  Stall: the result sits in an output register. A new item is taken while
//        it waits; if it is still not taken when the next result is ready,
//        the block holds that result in the lookup cycle until rsp.ready.
`default_nettype none

module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int OFFSET_BITS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tlbpt_chan_if.sink   req,
    tlbpt_chan_if.source rsp
);
    import tlbpt_pkg::*;

    localparam int PW     = $clog2(PAGE_COUNT);     // page / frame width
    localparam int TW     = $clog2(TLB_ENTRIES);    // TLB index width
    localparam int RAW_W  = (OFFSET_BITS < ADDR_W) ? ADDR_W - OFFSET_BITS : 1;
    localparam int WIDE_W = PW + OFFSET_BITS;
    localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_COUNT - 1);
    localparam logic [TW-1:0] LAST_SLOT = TW'(TLB_ENTRIES - 1);

    // Raw page number is at most 12 bits and PAGE_COUNT at least 16, so the
    // quotient fits in 8 bits: eight conditional subtracts reduce it.
    function automatic logic [PW-1:0] page_wrap(input logic [RAW_W-1:0] raw);
        int v;
        v = int'(raw);
        for (int k = 7; k >= 0; k--)
        begin
            if (v >= (PAGE_COUNT << k))
            begin
                v = v - (PAGE_COUNT << k);
            end
        end
        return PW'(v);
    endfunction

    // ---------------------------------------------------------------- state
    tlbpt_state_t state_reg, state_next;

    logic [PW-1:0]          page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [PW-1:0]          clr_idx_reg;
    logic [PW-1:0]          next_frame_reg;
    logic [TW-1:0]          ptr_reg;
    logic [COUNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]     fault_cnt_reg, fault_cnt_next;
    logic [COUNT_W-1:0]     xlat_cnt_reg, xlat_cnt_next;

    logic          tlb_valid_reg [TLB_ENTRIES];
    logic [PW-1:0] tlb_tag_reg   [TLB_ENTRIES];
    logic [PW-1:0] tlb_frame_reg [TLB_ENTRIES];

    logic       rsp_valid_reg;
    tlbpt_rsp_t rsp_payload_reg;

    // ------------------------------------------------------ request decode
    logic [PW-1:0] req_page;
    logic          req_fire;

    generate
        if (OFFSET_BITS < ADDR_W)
        begin : g_page
            assign req_page = page_wrap(req.payload.logical_address[ADDR_W-1:OFFSET_BITS]);
        end
        else
        begin : g_nopage
            assign req_page = '0;
        end
    endgenerate

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    // ------------------------------------------------------ page-table RAM
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [PW:0]   ram_wdata;
    logic [PW-1:0] ram_raddr;
    logic [PW:0]   ram_rdata;

    // read address follows the incoming page while idle, then holds
    assign ram_raddr = (state_reg == S_IDLE) ? req_page : page_reg;

    tlbpt_ram #(
        .WIDTH (PW + 1),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic          tbl_valid;
    logic [PW-1:0] tbl_frame;
    assign tbl_valid = ram_rdata[PW];
    assign tbl_frame = ram_rdata[PW-1:0];

    // --------------------------------------------------------- TLB compare
    logic          tlb_hit;
    logic [PW-1:0] tlb_frame_hit;

    always_comb
    begin
        tlb_hit       = 1'b0;
        tlb_frame_hit = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            if (!tlb_hit && tlb_valid_reg[i] && tlb_tag_reg[i] == page_reg)
            begin
                tlb_hit       = 1'b1;
                tlb_frame_hit = tlb_frame_reg[i];
            end
        end
    end

    // ------------------------------------------------------------- resolve
    logic          look_fire;
    logic          fault;
    logic [PW-1:0] frame_sel;
    logic [WIDE_W-1:0] phys_wide;

    assign look_fire = (state_reg == S_LOOK) && (!rsp_valid_reg || rsp.ready);
    assign fault     = !tlb_hit && !tbl_valid;
    assign frame_sel = tlb_hit ? tlb_frame_hit : (tbl_valid ? tbl_frame : next_frame_reg);
    assign phys_wide = {frame_sel, offset_reg};

    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        xlat_cnt_next  = xlat_cnt_reg;
        if (look_fire)
        begin
            if (tlb_hit && hit_cnt_reg != '1)
            begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
            if (fault && fault_cnt_reg != '1)
            begin
                fault_cnt_next = fault_cnt_reg + 1'b1;
            end
            if (xlat_cnt_reg != '1)
            begin
                xlat_cnt_next = xlat_cnt_reg + 1'b1;
            end
        end
    end

    // RAM write: zero during the clearing pass, {valid, frame} on a fault
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = page_reg;
        ram_wdata = {1'b1, next_frame_reg};
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end
        else if (look_fire && fault)
        begin
            ram_we = 1'b1;
        end
    end

    // ----------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (look_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            next_frame_reg <= '0;
            ptr_reg        <= '0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            xlat_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tlb_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            xlat_cnt_reg  <= xlat_cnt_next;

            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end

            if (look_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (look_fire && !tlb_hit)
            begin
                tlb_valid_reg[ptr_reg] <= 1'b1;
                ptr_reg <= (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
            end

            if (look_fire && fault)
            begin
                next_frame_reg <= (next_frame_reg == LAST_PAGE) ? '0 : next_frame_reg + 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            page_reg   <= req_page;
            offset_reg <= req.payload.logical_address[OFFSET_BITS-1:0];
        end

        if (look_fire && !tlb_hit)
        begin
            tlb_tag_reg[ptr_reg]   <= page_reg;
            tlb_frame_reg[ptr_reg] <= frame_sel;
        end

        if (look_fire)
        begin
            rsp_payload_reg.physical_address  <= ADDR_W'(phys_wide);
            rsp_payload_reg.tlb_hit           <= tlb_hit;
            rsp_payload_reg.page_fault        <= fault;
            rsp_payload_reg.hit_total         <= hit_cnt_next;
            rsp_payload_reg.fault_total       <= fault_cnt_next;
            rsp_payload_reg.translation_total <= xlat_cnt_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

endmodule

`default_nettype wire

/* hw/rtl/tlbpt_ram.sv */
// Generic simple dual-port RAM, one write port, registered read.
`default_nettype none

module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

/* hw/rtl/tlbpt_checker.sv */
// Port-level assertions for the translator, bound to the top level.
`default_nettype none

module tlbpt_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire tlbpt_pkg::tlbpt_rsp_t rsp_payload
);
    import tlbpt_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("stalled result changed");

    // one item at a time: busy the cycle after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // a fresh result is registered at the lookup edge that ends the state entered at its accept
    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without request");

    // flags and totals agree
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_payload.tlb_hit && rsp_payload.page_fault)
                      && rsp_payload.translation_total != '0
                      && (!rsp_payload.tlb_hit || rsp_payload.hit_total != '0)
                      && (!rsp_payload.page_fault || rsp_payload.fault_total != '0))
        else $error("flags inconsistent with totals");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

`default_nettype wire
